// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int OFFSET_W   = 12;
   localparam int OFF_CALC_W = (CELL_W + 1 > OFFSET_W) ? CELL_W + 1 : OFFSET_W;

   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int NUMBER_W   = 31;
   localparam int DIGIT_W    = 4;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
   localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);
   localparam int BIT_CNT_W  = $clog2(NUMBER_W + 1);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd97;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_INT  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHAR,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } dabble_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic [DIGIT_W-1:0] digit;
   } dabble_status_type;

endpackage

// ===== design/tcw_dabble.sv =====
// ----------------------------------------------------------------------------
// tcw_dabble
// Bit-serial binary to BCD converter with a digit shift-out, one bit per cycle.
// ----------------------------------------------------------------------------
module tcw_dabble (
   input  logic                             clock,
   input  logic                             reset,
   input  tcw_pkg::dabble_ctrl_type         ctrl,
   input  logic [tcw_pkg::NUMBER_W-1:0]     number,
   output tcw_pkg::dabble_status_type       status
);

   logic [tcw_pkg::NUMBER_W-1:0]  bin_ff, bin_in;
   logic [tcw_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [tcw_pkg::BCD_W-1:0]     bcd_adj;
   logic [tcw_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      for (int i = 0; i < tcw_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] >= 4'd5) begin
            bcd_adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] =
               bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] =
               bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         bin_in = number;
         bcd_in = '0;
         cnt_in = tcw_pkg::BIT_CNT_W'(tcw_pkg::NUMBER_W);
      end else if (cnt_ff != '0) begin
         bcd_in = {bcd_adj[tcw_pkg::BCD_W-2:0], bin_ff[tcw_pkg::NUMBER_W-1]};
         bin_in = {bin_ff[tcw_pkg::NUMBER_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0], {tcw_pkg::DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy  = (cnt_ff != '0);
   assign status.digit = bcd_ff[tcw_pkg::BCD_W-1 -: tcw_pkg::DIGIT_W];

endmodule

// ===== design/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console writer: character and decimal integer cell writes.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  req_    | in        | one character (tuser 0) or one integer (tuser 1)
//  rsp_    | out       | one cell write, tlast on the final write of a request
//  csr_    | in        | attribute byte write
//
//  Newline: no cell write, only the cursor moves; other character: one cell
//  write, held back while rsp_ stalls. Integer: the bit-serial converter loads
//  and shifts in all 31 bits, then the 10 BCD digits are shifted out in turn,
//  leading zeros skipped without a write, the rest held back while rsp_ stalls.
//  One request in flight at a time; req_tready is low until it is finished.
//  Reset: synchronous, cursor to the top left cell, attribute to 97.
module text_console_writer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code, [38:8] number, [39] zero
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] op
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] byte_offset, [19:12] char_byte, [27:20] attr_byte, [31:28] zero
   output logic [tcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [tcw_pkg::ATTR_W-1:0]         csr_wdata
);

   tcw_pkg::state_type          state_ff, state_in;
   tcw_pkg::dabble_ctrl_type    dab_ctrl;
   tcw_pkg::dabble_status_type  dab_status;

   logic [tcw_pkg::ATTR_W-1:0]   attr_ff, attr_in;
   logic [tcw_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic [tcw_pkg::CELL_W-1:0]   cell_ff, cell_in;
   logic [tcw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tcw_pkg::LEFT_W-1:0]   left_ff, left_in;
   logic                         started_ff, started_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [tcw_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [tcw_pkg::ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_accept;
   logic                         slot_free;
   logic                         newline;
   logic                         emit;
   logic                         emit_last;
   logic                         skip;
   logic [tcw_pkg::CHAR_W-1:0]   emit_char;
   logic [tcw_pkg::OFF_CALC_W-1:0] offset_wide;
   logic                         req_op;
   logic [tcw_pkg::CHAR_W-1:0]   req_char;
   logic [tcw_pkg::NUMBER_W-1:0] req_number;
   logic                         last_digit;
   logic                         lead_zero;

   assign req_op     = req_tuser[0];
   assign req_char   = req_tdata[tcw_pkg::CHAR_W-1:0];
   assign req_number = req_tdata[tcw_pkg::CHAR_W +: tcw_pkg::NUMBER_W];

   assign req_tready = (state_ff == tcw_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign last_digit = (left_ff == tcw_pkg::LEFT_W'(1));
   assign lead_zero  = (dab_status.digit == '0) && !started_ff && !last_digit;

   tcw_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (dab_ctrl),
      .number (req_number),
      .status (dab_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_op == tcw_pkg::OP_INT) begin
                  state_in = tcw_pkg::ST_CONV;
               end else if (req_char != tcw_pkg::NL_CODE) begin
                  state_in = tcw_pkg::ST_CHAR;
               end
            end
         end
         tcw_pkg::ST_CHAR: begin
            if (slot_free) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_CONV: begin
            if (!dab_status.busy) begin
               state_in = tcw_pkg::ST_EMIT;
            end
         end
         tcw_pkg::ST_EMIT: begin
            if (!lead_zero && slot_free && last_digit) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      dab_ctrl  = '0;
      newline   = 1'b0;
      emit      = 1'b0;
      emit_last = 1'b0;
      skip      = 1'b0;
      emit_char = char_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            dab_ctrl.load = req_accept && (req_op == tcw_pkg::OP_INT);
            newline = req_accept && (req_op == tcw_pkg::OP_CHAR) &&
                      (req_char == tcw_pkg::NL_CODE);
         end
         tcw_pkg::ST_CHAR: begin
            emit      = slot_free;
            emit_last = 1'b1;
         end
         tcw_pkg::ST_CONV: begin
         end
         tcw_pkg::ST_EMIT: begin
            skip           = lead_zero;
            emit           = !lead_zero && slot_free;
            emit_last      = last_digit;
            emit_char      = tcw_pkg::ASCII_ZERO + tcw_pkg::CHAR_W'(dab_status.digit);
            dab_ctrl.shift = skip || emit;
         end
         default: begin
         end
      endcase
   end

   assign offset_wide = tcw_pkg::OFF_CALC_W'({cell_ff, 1'b0});

   always_comb begin
      attr_in    = csr_we ? csr_wdata : attr_ff;
      char_in    = (req_accept) ? req_char : char_ff;
      left_in    = left_ff;
      started_in = started_ff;
      if (dab_ctrl.load) begin
         left_in    = tcw_pkg::LEFT_W'(tcw_pkg::BCD_DIGITS);
         started_in = 1'b0;
      end else if (dab_ctrl.shift) begin
         left_in = left_ff - 1'b1;
         if (emit) begin
            started_in = 1'b1;
         end
      end

      cell_in = cell_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (emit || newline) begin
         if (emit && (col_ff != tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))) begin
            col_in  = col_ff + 1'b1;
            cell_in = cell_ff + 1'b1;
         end else if (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
            col_in  = '0;
            row_in  = '0;
            cell_in = '0;
         end else begin
            col_in  = '0;
            row_in  = row_ff + 1'b1;
            cell_in = cell_ff + tcw_pkg::CELL_W'(tcw_pkg::COLUMNS)
                      - tcw_pkg::CELL_W'(col_ff);
         end
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_offset_in = rsp_offset_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = offset_wide[tcw_pkg::OFFSET_W-1:0];
         rsp_char_in   = emit_char;
         rsp_attr_in   = attr_ff;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         cell_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attr_ff      <= attr_in;
         cell_ff      <= cell_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         started_ff   <= started_in;
      end
      char_ff       <= char_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(tcw_pkg::RSP_DATA_W - tcw_pkg::OFFSET_W - tcw_pkg::CHAR_W
                          - tcw_pkg::ATTR_W){1'b0}},
                        rsp_attr_ff, rsp_char_ff, rsp_offset_ff};

`ifndef SYNTHESIS
   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      cell_ff < tcw_pkg::CELL_W'(tcw_pkg::CELLS))
      else $error("cursor cell beyond the screen");

   a_cell_matches_rowcol: assert property (@(posedge clock) disable iff (reset)
      32'(cell_ff) == 32'(row_ff) * 32'(tcw_pkg::COLUMNS) + 32'(col_ff))
      else $error("cursor cell disagrees with row and column");

   a_emit_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_EMIT) |-> (left_ff != '0) && !dab_status.busy)
      else $error("digit emit without a finished conversion");

   a_char_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_CHAR) && slot_free |=> rsp_valid_ff && rsp_last_ff)
      else $error("character write did not produce a final transaction");
`endif

endmodule
